// ===== design/lrukv_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lrukv_pkg
// Shared types and constants of the LRU key/value cache: request and result
// layouts, operation codes, controller states and configuration defaults.
// ============================================================================
package lrukv_pkg;

    // Built number of entries (default of the top-level parameter).
    localparam int unsigned ENTRIES_DEF = 16;

    // Width of one key or one value.
    localparam int unsigned DATA_W = 32;

    // Capacity register.
    localparam int unsigned CAP_W     = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Operation codes.
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic                     op;
        logic signed [DATA_W-1:0] lookup_key;
        logic signed [DATA_W-1:0] write_value;
    } t_req;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_value;
        logic                     evicted;
        logic signed [DATA_W-1:0] evicted_key;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE,
        ST_RESULT
    } t_state;

endpackage

// ===== design/lrukv_mem.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lrukv_mem
// Entry store: one write port and one read port, read data registered.
// Each word holds {key, value, recency rank}.
// ============================================================================
module lrukv_mem #(
    parameter int unsigned ENTRIES = lrukv_pkg::ENTRIES_DEF,
    parameter int unsigned AW      = 4,
    parameter int unsigned DW      = 68
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);

    logic [DW-1:0] mem [ENTRIES];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/lrukv_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lrukv_ctrl
// Sequencer of the cache: scans the entry store once to find the key, the
// oldest entry and the first free slot, decides the access, then, unless a
// get missed, sweeps the store again to age ranks and write the touched entry.
// ============================================================================
module lrukv_ctrl #(
    parameter int unsigned ENTRIES = lrukv_pkg::ENTRIES_DEF,
    parameter int unsigned AW      = 4,
    parameter int unsigned RW      = 4,
    parameter int unsigned CW      = 5,
    parameter int unsigned DW      = 68
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  lrukv_pkg::t_req               i_req,
    input  logic [lrukv_pkg::CAP_W-1:0]   i_capacity,
    input  logic                          i_out_free,
    output logic                          o_rsp_push,
    output lrukv_pkg::t_rsp               o_rsp,
    output logic                          o_rd_en,
    output logic [AW-1:0]                 o_rd_addr,
    input  logic [DW-1:0]                 i_rd_data,
    output logic                          o_wr_en,
    output logic [AW-1:0]                 o_wr_addr,
    output logic [DW-1:0]                 o_wr_data
);

    localparam int unsigned KW   = lrukv_pkg::DATA_W;
    localparam int unsigned LW   = RW + 1;
    localparam int unsigned CMPW = (CW > lrukv_pkg::CAP_W) ? CW : lrukv_pkg::CAP_W;

    lrukv_pkg::t_state r_state, n_state;

    lrukv_pkg::t_req   r_req;
    lrukv_pkg::t_rsp   r_rsp, n_rsp;
    logic [CW-1:0]     r_cnt;
    logic              r_dv;
    logic [AW-1:0]     r_di;
    logic              r_dvld;
    logic [ENTRIES-1:0] r_valid;
    logic [CW-1:0]     r_used;

    logic              r_found;
    logic [AW-1:0]     r_hit_slot;
    logic [RW-1:0]     r_hit_rank;
    logic [KW-1:0]     r_hit_val;
    logic              r_old_have;
    logic [RW-1:0]     r_old_rank;
    logic [AW-1:0]     r_old_slot;
    logic [KW-1:0]     r_old_key;
    logic              r_free_have;
    logic [AW-1:0]     r_free_slot;
    logic [AW-1:0]     r_target, n_target;
    logic [LW-1:0]     r_limit, n_limit;

    logic              accept;
    logic              rd_issue;
    logic              cnt_done;
    logic [KW-1:0]     d_key;
    logic [KW-1:0]     d_val;
    logic [RW-1:0]     d_rank;
    logic              key_match;
    logic              older;
    logic [CMPW-1:0]   cap_x;
    logic [CMPW-1:0]   ent_x;
    logic [CMPW-1:0]   eff_cap;
    logic              room;
    logic              n_insert;
    logic              n_count_up;
    logic [RW-1:0]     w_rank;

    assign d_key  = i_rd_data[DW-1 -: KW];
    assign d_val  = i_rd_data[RW+KW-1 -: KW];
    assign d_rank = i_rd_data[RW-1:0];

    assign cnt_done  = (r_cnt == CW'(ENTRIES));
    assign key_match = r_dv && r_dvld && (d_key == r_req.lookup_key);
    assign older     = r_dv && r_dvld && (!r_old_have || (d_rank > r_old_rank));

    // Effective capacity: zero acts as one, anything above the store as the store.
    assign cap_x   = CMPW'(i_capacity);
    assign ent_x   = CMPW'(ENTRIES);
    assign eff_cap = (cap_x == '0) ? CMPW'(1) : ((cap_x > ent_x) ? ent_x : cap_x);
    assign room    = (CMPW'(r_used) < eff_cap);

    // Decision taken once the scan is complete.
    always_comb begin
        n_rsp      = '0;
        n_target   = r_hit_slot;
        n_limit    = {1'b0, r_hit_rank};
        n_insert   = 1'b0;
        n_count_up = 1'b0;
        if (r_found) begin
            n_rsp.hit = 1'b1;
            if (r_req.op == lrukv_pkg::OP_GET) begin
                n_rsp.read_value = r_hit_val;
            end
        end else if (r_req.op == lrukv_pkg::OP_PUT) begin
            n_insert = 1'b1;
            if (room) begin
                // A fill ages every valid entry.
                n_target   = r_free_slot;
                n_limit    = LW'(ENTRIES);
                n_count_up = 1'b1;
            end else if (r_old_have) begin
                n_rsp.evicted     = 1'b1;
                n_rsp.evicted_key = r_old_key;
                n_target          = r_old_slot;
                n_limit           = {1'b0, r_old_rank};
            end else begin
                n_target   = '0;
                n_limit    = '0;
                n_count_up = 1'b1;
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lrukv_pkg::ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = lrukv_pkg::ST_SCAN;
                end
            end
            lrukv_pkg::ST_SCAN: begin
                if (cnt_done) begin
                    n_state = lrukv_pkg::ST_DECIDE;
                end
            end
            lrukv_pkg::ST_DECIDE: begin
                if (!r_found && (r_req.op == lrukv_pkg::OP_GET)) begin
                    n_state = lrukv_pkg::ST_RESULT;
                end else begin
                    n_state = lrukv_pkg::ST_UPDATE;
                end
            end
            lrukv_pkg::ST_UPDATE: begin
                if (cnt_done) begin
                    n_state = lrukv_pkg::ST_RESULT;
                end
            end
            lrukv_pkg::ST_RESULT: begin
                if (i_out_free) begin
                    n_state = lrukv_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lrukv_pkg::ST_IDLE;
            end
        endcase
    end

    // State-dependent outputs.
    always_comb begin
        o_req_ready = 1'b0;
        rd_issue    = 1'b0;
        o_rsp_push  = 1'b0;
        o_wr_en     = 1'b0;
        unique case (r_state)
            lrukv_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
            end
            lrukv_pkg::ST_SCAN: begin
                rd_issue = !cnt_done;
            end
            lrukv_pkg::ST_DECIDE: begin
                rd_issue = 1'b0;
            end
            lrukv_pkg::ST_UPDATE: begin
                rd_issue = !cnt_done;
                o_wr_en  = r_dv;
            end
            lrukv_pkg::ST_RESULT: begin
                o_rsp_push = i_out_free;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

    assign accept    = o_req_ready && i_req_valid;
    assign o_rd_en   = rd_issue;
    assign o_rd_addr = r_cnt[AW-1:0];
    assign o_rsp     = r_rsp;

    // Write-back of the sweep. The read of entry i+1 and the write of entry i
    // fall in the same cycle, so read and write never meet on one address.
    assign w_rank = (r_dvld && ({1'b0, d_rank} < r_limit)) ? (d_rank + RW'(1)) : d_rank;

    always_comb begin
        o_wr_addr = r_di;
        if (r_di == r_target) begin
            if (r_req.op == lrukv_pkg::OP_PUT) begin
                o_wr_data = {r_req.lookup_key, r_req.write_value, RW'(0)};
            end else begin
                o_wr_data = {d_key, d_val, RW'(0)};
            end
        end else begin
            o_wr_data = {d_key, d_val, w_rank};
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lrukv_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_dv        <= 1'b0;
            r_valid     <= '0;
            r_used      <= '0;
            r_found     <= 1'b0;
            r_old_have  <= 1'b0;
            r_free_have <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= rd_issue;
            if ((r_state == lrukv_pkg::ST_IDLE) || (r_state == lrukv_pkg::ST_DECIDE)) begin
                r_cnt <= '0;
            end else if (rd_issue) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (accept) begin
                r_found     <= 1'b0;
                r_old_have  <= 1'b0;
                r_free_have <= 1'b0;
            end else if (r_state == lrukv_pkg::ST_SCAN) begin
                if (key_match) begin
                    r_found <= 1'b1;
                end
                if (older) begin
                    r_old_have <= 1'b1;
                end
                if (r_dv && !r_dvld) begin
                    r_free_have <= 1'b1;
                end
            end
            if (r_state == lrukv_pkg::ST_DECIDE) begin
                if (n_insert) begin
                    r_valid[n_target] <= 1'b1;
                end
                if (n_count_up) begin
                    r_used <= r_used + CW'(1);
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_di   <= r_cnt[AW-1:0];
        r_dvld <= r_valid[r_cnt[AW-1:0]];
        if (accept) begin
            r_req <= i_req;
        end
        if (r_state == lrukv_pkg::ST_SCAN) begin
            if (key_match && !r_found) begin
                r_hit_slot <= r_di;
                r_hit_rank <= d_rank;
                r_hit_val  <= d_val;
            end
            if (older) begin
                r_old_rank <= d_rank;
                r_old_slot <= r_di;
                r_old_key  <= d_key;
            end
            if (r_dv && !r_dvld && !r_free_have) begin
                r_free_slot <= r_di;
            end
        end
        if (r_state == lrukv_pkg::ST_DECIDE) begin
            r_target <= n_target;
            r_limit  <= n_limit;
            r_rsp    <= n_rsp;
        end
    end

    // The number of valid entries is always the use count.
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == r_used)
        else $error("valid bits disagree with use count");

    // A fill is only decided when the scan has found a free slot.
    a_free_on_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lrukv_pkg::ST_DECIDE) && !r_found
        && (r_req.op == lrukv_pkg::OP_PUT) && room |-> r_free_have)
        else $error("fill without a free slot");

    // A hit always points at a valid entry.
    a_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> r_valid[r_hit_slot])
        else $error("hit on an invalid entry");

    // After a result is handed over the sequencer is idle again.
    a_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_push |=> (r_state == lrukv_pkg::ST_IDLE))
        else $error("result pushed without returning to idle");

endmodule

// ===== design/lru_key_value_cache.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lru_key_value_cache
// Fully associative key/value cache with least-recently-used replacement,
// a capacity register and a registered result port.
// ============================================================================
//
//  Channel    Signals                               Direction  Moves
//  request    i_req_valid / o_req_ready / i_req     in         op, key, value
//  result     o_rsp_valid / i_rsp_ready / o_rsp     out        hit, data, eviction
//  config     i_cfg_valid / o_cfg_ready / i_cfg_data in        capacity
//
//  A request is served through the single read port of the entry store: one
//  sweep reads every entry to find the key, the oldest entry and a free slot,
//  and a second sweep, which a get that misses does not take, ages the ranks
//  and writes the touched entry. Reset is synchronous and active low; it
//  empties the cache and sets the capacity to 16. The entry store itself is
//  not cleared, since the valid bits guard every read. A stalled result port
//  holds the sequencer in its result state while one finished result waits
//  in the output register; a new request can be taken as soon as that
//  result is parked there.
//
module lru_key_value_cache #(
    parameter int unsigned ENTRIES = lrukv_pkg::ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  lrukv_pkg::t_req             i_req,
    output logic                        o_rsp_valid,
    input  logic                        i_rsp_ready,
    output lrukv_pkg::t_rsp             o_rsp,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lrukv_pkg::CAP_W-1:0] i_cfg_data
);

    // Entry address, rank and counter widths follow the store depth.
    localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned RW = AW;
    localparam int unsigned CW = $clog2(ENTRIES + 1);
    localparam int unsigned DW = 2 * lrukv_pkg::DATA_W + RW;

    logic [lrukv_pkg::CAP_W-1:0] r_capacity;
    logic                        r_out_valid;
    lrukv_pkg::t_rsp             r_out;

    logic            out_free;
    logic            rsp_push;
    lrukv_pkg::t_rsp rsp;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic [DW-1:0]   rd_data;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [DW-1:0]   wr_data;

    // The capacity register takes a write in any cycle. Writing it does not
    // touch the stored entries; a lowered capacity only takes effect through
    // later evictions.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= lrukv_pkg::CAP_RESET;
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_data;
        end
    end

    // Output register: the slot is free when empty or being drained now.
    assign out_free = !r_out_valid || i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rsp_push) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rsp_push) begin
            r_out <= rsp;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    lrukv_ctrl #(
        .ENTRIES (ENTRIES),
        .AW      (AW),
        .RW      (RW),
        .CW      (CW),
        .DW      (DW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .i_capacity  (r_capacity),
        .i_out_free  (out_free),
        .o_rsp_push  (rsp_push),
        .o_rsp       (rsp),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    lrukv_mem #(
        .ENTRIES (ENTRIES),
        .AW      (AW),
        .DW      (DW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

endmodule
